FILE: rtl/core/mfva_pkg.sv
// Shared types, constants and helper functions of the MIDI FM voice allocator.
// No dependencies; imported by every module of the block.
package mfva_pkg;

    localparam int NUM_VOICES = 9;
    localparam int AGE_WIDTH  = 32;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SLOT_W     = 4;
    localparam int NOTE_W     = 7;
    localparam int CHAN_W     = 4;
    localparam int NUM_CHAN   = 16;
    localparam int PRESET_CH  = 6;     // channels with a nonzero program after reset
    localparam int FNUM_W     = 10;    // fnum never exceeds 1023
    localparam int BLK_W      = 3;
    localparam int OCT_W      = 4;
    localparam int SEMITONES  = 12;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // MIDI status types (high nibble, kept in place)
    localparam logic [7:0] MSG_TYPE_MASK = 8'hF0;
    localparam logic [7:0] MSG_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MSG_NOTE_ON   = 8'h90;
    localparam logic [7:0] MSG_PROG_CHG  = 8'hC0;

    // synth register map
    localparam logic [7:0] REG_KEY_BASE  = 8'hB0;
    localparam logic [7:0] REG_FNUM_LO   = 8'hA0;
    localparam logic [7:0] KEY_ON_BIT    = 8'h20;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PATCH = 1'b1;
    localparam logic OPC_MIDI   = 1'b0;
    localparam logic OPC_ALLOFF = 1'b1;

    typedef enum logic [1:0] {
        OP_NOTE_ON,
        OP_NOTE_OFF,
        OP_PROG,
        OP_ALL_OFF
    } t_cmd_op;

    // decoded command passed from front end to back end
    typedef struct packed {
        t_cmd_op             op;
        logic [CHAN_W-1:0]   chan;
        logic [NOTE_W-1:0]   note;    // note number, or program number
    } t_cmd;

    typedef struct packed {
        logic                kind;
        logic [SLOT_W-1:0]   slot;
        logic [NOTE_W-1:0]   prog;
        logic [7:0]          addr;
        logic [7:0]          data;
        logic                last;
    } t_result;

    // round(172.86 * 2^(s/12))
    function automatic logic [FNUM_W-1:0] semi_fnum(input logic [OCT_W-1:0] semi);
        logic [FNUM_W-1:0] f;
        case (semi)
            4'd0:    f = 10'd173;
            4'd1:    f = 10'd183;
            4'd2:    f = 10'd194;
            4'd3:    f = 10'd206;
            4'd4:    f = 10'd218;
            4'd5:    f = 10'd231;
            4'd6:    f = 10'd244;
            4'd7:    f = 10'd259;
            4'd8:    f = 10'd274;
            4'd9:    f = 10'd291;
            4'd10:   f = 10'd308;
            4'd11:   f = 10'd326;
            default: f = '0;
        endcase
        return f;
    endfunction

    // note / 12 by threshold compares
    function automatic logic [OCT_W-1:0] note_octave(input logic [NOTE_W-1:0] note);
        logic [OCT_W-1:0] oct;
        oct = '0;
        for (int k = 1; k <= 10; k++) begin
            if (note >= NOTE_W'(SEMITONES * k)) oct = OCT_W'(k);
        end
        return oct;
    endfunction

endpackage

FILE: rtl/core/mfva_front.sv
// Front end: accepts MIDI items, decodes them into commands, drops unsupported types.
// Depends on mfva_pkg.
module mfva_front import mfva_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_status,
    input  logic [NOTE_W-1:0] i_data1,
    input  logic [NOTE_W-1:0] i_data2,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    logic [7:0] w_type;
    logic       w_keep;
    t_cmd       w_cmd;
    logic       r_valid;
    t_cmd       r_cmd;

    always_comb begin
        w_type      = i_status & MSG_TYPE_MASK;
        w_keep      = 1'b1;
        w_cmd.chan  = i_status[CHAN_W-1:0];
        w_cmd.note  = i_data1;
        w_cmd.op    = OP_NOTE_ON;
        if (i_opcode == OPC_ALLOFF) begin
            w_cmd.op = OP_ALL_OFF;
        end else if (w_type == MSG_PROG_CHG) begin
            w_cmd.op = OP_PROG;
        end else if (w_type == MSG_NOTE_OFF || (w_type == MSG_NOTE_ON && i_data2 == '0)) begin
            w_cmd.op = OP_NOTE_OFF;
        end else if (w_type == MSG_NOTE_ON) begin
            w_cmd.op = OP_NOTE_ON;
        end else begin
            w_keep = 1'b0;
        end
    end

    // nothing is taken while reset is held
    assign o_in_ready  = i_rst_n && (!r_valid || i_cmd_ready);
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && w_keep;
            r_cmd   <= w_cmd;
        end
    end

endmodule

FILE: rtl/core/mfva_fifo.sv
// Command queue between front and back end.
// Depends on mfva_pkg.
module mfva_fifo import mfva_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_data
);

    t_cmd                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_push_ready = (r_cnt != (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_data;
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

FILE: rtl/core/mfva_back.sv
// Back end: voice state, program table, voice scan and result sequencing.
// Depends on mfva_pkg.
module mfva_back import mfva_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    output logic    o_cmd_ready,
    input  t_cmd    i_cmd,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} t_state;

    t_state                r_state;
    t_cmd_op               r_op;
    logic [CHAN_W-1:0]     r_chan;
    logic [NOTE_W-1:0]     r_note;
    logic [VIDX_W-1:0]     r_idx;
    logic [VIDX_W-1:0]     r_best;
    logic [AGE_WIDTH-1:0]  r_best_age;
    logic [VIDX_W-1:0]     r_slot;
    logic [1:0]            r_step;
    logic [NOTE_W-1:0]     r_prog;
    logic                  r_out_valid;
    t_result               r_out;
    logic [NOTE_W-1:0]     r_prog_tbl [NUM_CHAN];
    logic                  r_active   [NUM_VOICES];
    logic [CHAN_W-1:0]     r_vchan    [NUM_VOICES];
    logic [NOTE_W-1:0]     r_vnote    [NUM_VOICES];
    logic [AGE_WIDTH-1:0]  r_vage     [NUM_VOICES];
    logic [AGE_WIDTH-1:0]  r_age_ctr;

    logic                  w_last_idx;
    logic                  w_match;
    logic                  w_older;
    logic                  w_commit;
    logic [VIDX_W-1:0]     w_pick;
    logic                  w_out_free;
    logic [OCT_W-1:0]      w_oct;
    logic [OCT_W-1:0]      w_semi;
    logic [FNUM_W-1:0]     w_fnum;
    logic [BLK_W-1:0]      w_blk;
    logic [7:0]            w_slot8;
    t_result               w_res;

    always_comb begin
        w_last_idx = (r_idx == VIDX_W'(NUM_VOICES - 1));
        w_match    = r_active[r_idx] && (r_vchan[r_idx] == r_chan)
                     && (r_vnote[r_idx] == r_note);
        // strict compare keeps the lowest index on ties
        w_older    = (r_idx == '0) || (r_vage[r_idx] < r_best_age);
        w_commit   = !r_active[r_idx] || w_last_idx;
        if (!r_active[r_idx] || w_older) w_pick = r_idx;
        else                             w_pick = r_best;
        w_out_free = !r_out_valid || i_res_ready;

        w_oct  = note_octave(r_note);
        w_semi = OCT_W'(r_note - NOTE_W'(w_oct) * NOTE_W'(SEMITONES));
        w_fnum = semi_fnum(w_semi);
        if (w_oct == '0)                  w_blk = '0;
        else if (w_oct > OCT_W'(8))       w_blk = '1;
        else                              w_blk = BLK_W'(w_oct - 1'b1);

        w_res         = '0;
        w_res.kind    = KIND_WRITE;
        w_res.slot    = SLOT_W'(r_slot);
        w_slot8       = 8'(r_slot);
        w_res.addr    = REG_KEY_BASE + w_slot8;
        case (r_op)
            OP_NOTE_ON: begin
                case (r_step)
                    2'd0: begin
                        w_res.kind = KIND_PATCH;
                        w_res.prog = r_prog;
                        w_res.addr = '0;
                    end
                    2'd1: ;
                    2'd2: begin
                        w_res.addr = REG_FNUM_LO + w_slot8;
                        w_res.data = w_fnum[7:0];
                    end
                    default: begin
                        w_res.data = KEY_ON_BIT | {3'b000, w_blk, w_fnum[9:8]};
                        w_res.last = 1'b1;
                    end
                endcase
            end
            OP_NOTE_OFF: w_res.last = 1'b1;
            OP_ALL_OFF: begin
                w_res.slot = SLOT_W'(r_idx);
                w_res.addr = REG_KEY_BASE + 8'(r_idx);
                w_res.last = w_last_idx;
            end
            default: ;
        endcase
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_age_ctr   <= '0;
            for (int v = 0; v < NUM_VOICES; v++) r_active[v] <= 1'b0;
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_prog_tbl[c] <= (c < PRESET_CH) ? NOTE_W'(c + 1) : '0;
            end
        end else begin
            // in S_EMIT the output slot is handled below
            if (r_out_valid && i_res_ready && r_state != S_EMIT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op   <= i_cmd.op;
                        r_chan <= i_cmd.chan;
                        r_note <= i_cmd.note;
                        r_idx  <= '0;
                        r_step <= '0;
                        case (i_cmd.op)
                            OP_PROG: r_prog_tbl[i_cmd.chan] <= i_cmd.note;
                            OP_ALL_OFF: begin
                                for (int v = 0; v < NUM_VOICES; v++) r_active[v] <= 1'b0;
                                r_state <= S_EMIT;
                            end
                            default: r_state <= S_SCAN;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_NOTE_OFF) begin
                        if (w_match) begin
                            r_slot          <= r_idx;
                            r_active[r_idx] <= 1'b0;
                            r_state         <= S_EMIT;
                        end else if (w_last_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (w_commit) begin
                        r_slot           <= w_pick;
                        r_active[w_pick] <= 1'b1;
                        r_vchan[w_pick]  <= r_chan;
                        r_vnote[w_pick]  <= r_note;
                        r_vage[w_pick]   <= r_age_ctr + AGE_WIDTH'(1);
                        r_age_ctr        <= r_age_ctr + AGE_WIDTH'(1);
                        r_prog           <= r_prog_tbl[r_chan];
                        r_state          <= S_EMIT;
                    end else begin
                        if (w_older) begin
                            r_best     <= r_idx;
                            r_best_age <= r_vage[r_idx];
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= w_res;
                        r_step      <= r_step + 1'b1;
                        if (w_res.last)             r_state <= S_IDLE;
                        else if (r_op == OP_ALL_OFF) r_idx  <= r_idx + 1'b1;
                    end else if (r_out_valid && i_res_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/midi_fm_voice_allocator.sv
// Top level of the MIDI FM voice allocator: front end, command queue, back end.
// Depends on mfva_pkg, mfva_front, mfva_fifo, mfva_back.
//
// Maps MIDI events onto NUM_VOICES FM voices and emits synth register writes
// and patch load requests, one result per transaction on the output channel;
// o_last marks the final result of an input item. The front end decodes and
// registers each item and drops types it does not handle; a four-entry queue
// holds decoded commands so input and output can stall independently. The
// back end scans the voices one per cycle and per command gives: program
// change, no result; note-off, a scan of up to NUM_VOICES voices plus one
// result if one matches; note-on, a scan of up to NUM_VOICES voices (fewer
// when a free voice turns up early) plus four results; all notes off,
// NUM_VOICES results. One result leaves per cycle when the sink is ready.
// No clearing pass is needed after reset.
module midi_fm_voice_allocator import mfva_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_opcode,
    input  logic [7:0]        i_status,
    input  logic [NOTE_W-1:0] i_data1,
    input  logic [NOTE_W-1:0] i_data2,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_kind,
    output logic [SLOT_W-1:0] o_voice_slot,
    output logic [NOTE_W-1:0] o_program_res,
    output logic [7:0]        o_reg_addr,
    output logic [7:0]        o_reg_data,
    output logic              o_last
);

    // decoded command, front end to queue
    logic    w_fe_valid;
    logic    w_fe_ready;
    t_cmd    w_fe_cmd;
    // queue to back end
    logic    w_be_valid;
    logic    w_be_ready;
    t_cmd    w_be_cmd;
    t_result w_res;

    mfva_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_status    (i_status),
        .i_data1     (i_data1),
        .i_data2     (i_data2),
        .o_cmd_valid (w_fe_valid),
        .i_cmd_ready (w_fe_ready),
        .o_cmd       (w_fe_cmd)
    );

    mfva_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fe_valid),
        .o_push_ready (w_fe_ready),
        .i_push_data  (w_fe_cmd),
        .o_pop_valid  (w_be_valid),
        .i_pop_ready  (w_be_ready),
        .o_pop_data   (w_be_cmd)
    );

    mfva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_be_valid),
        .o_cmd_ready (w_be_ready),
        .i_cmd       (w_be_cmd),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (w_res)
    );

    // result register fields straight to the ports
    assign o_kind        = w_res.kind;
    assign o_voice_slot  = w_res.slot;
    assign o_program_res = w_res.prog;
    assign o_reg_addr    = w_res.addr;
    assign o_reg_data    = w_res.data;
    assign o_last        = w_res.last;

endmodule

FILE: rtl/core/mfva_checker.sv
// Port-level checks for the MIDI FM voice allocator, bound to the top level.
// Depends on mfva_pkg and midi_fm_voice_allocator.
module mfva_checker import mfva_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_opcode,
    input logic [7:0]        i_status,
    input logic [NOTE_W-1:0] i_data1,
    input logic [NOTE_W-1:0] i_data2,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic              o_kind,
    input logic [SLOT_W-1:0] o_voice_slot,
    input logic [NOTE_W-1:0] o_program_res,
    input logic [7:0]        o_reg_addr,
    input logic [7:0]        o_reg_data,
    input logic              o_last
);

    // no results right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_reg_addr)
        && $stable(o_reg_data) && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // a patch request is never the final result and carries no write
    a_patch_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> !o_last && o_reg_addr == 8'h00 && o_reg_data == 8'h00)
        else $error("malformed patch request");

    // a write targets its own voice's key or fnum register
    a_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> o_program_res == '0
        && o_voice_slot < SLOT_W'(NUM_VOICES)
        && (o_reg_addr == REG_KEY_BASE + 8'(o_voice_slot)
            || o_reg_addr == REG_FNUM_LO + 8'(o_voice_slot)))
        else $error("write address does not match voice");

    // an accepted patch request is followed by no result or by the key-off of the same voice
    a_patch_then_keyoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_kind |=> !o_out_valid
        || (!o_kind && o_reg_data == 8'h00 && o_voice_slot == $past(o_voice_slot)))
        else $error("patch request not followed by key-off");

endmodule

bind midi_fm_voice_allocator mfva_checker u_mfva_checker (.*);
